@@ rtl/core/dhf_pkg.sv @@
`default_nettype none
package dhf_pkg;

  localparam int MAX_WIDTH_DEF  = 640;
  localparam int MAX_HEIGHT_DEF = 480;

  localparam int REQ_W   = 2;
  localparam int ROW_W   = 9;
  localparam int COL_W   = 10;
  localparam int PIX_W   = 16;
  localparam int FW_W    = 10;
  localparam int FH_W    = 9;
  localparam int CFG_D_W = 10;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 9'd480;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_PROCESS = 2'd1,
    REQ_READ    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_ANY_RD,
    ST_ANY_CHK,
    ST_FILL_RD,
    ST_FILL_CHK,
    ST_RING,
    ST_SEG,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_MED_RD,
    ST_MED_CAP,
    ST_MED_WR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/dhf_if.sv @@
`default_nettype none
interface dhf_req_if;
  logic                        valid;
  logic                        ready;
  logic [dhf_pkg::REQ_W-1:0]   req_type;
  logic [dhf_pkg::ROW_W-1:0]   row;
  logic [dhf_pkg::COL_W-1:0]   col;
  logic [dhf_pkg::PIX_W-1:0]   pixel_value;

  modport source (output valid, req_type, row, col, pixel_value, input ready);
  modport sink   (input valid, req_type, row, col, pixel_value, output ready);
endinterface

interface dhf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dhf_pkg::PIX_W-1:0]   read_value;
  logic                        address_error;

  modport source (output valid, read_value, address_error, input ready);
  modport sink   (input valid, read_value, address_error, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dhf_ram.sv @@
`default_nettype none
module dhf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/depth_hole_fill_median_core.sv @@
`default_nettype none
// Depth frame hole filler with a 3x3 median, built around two frame memories.
// Requests arrive on the req channel (valid/ready); every accepted transaction
// produces exactly one response transaction on the rsp channel.
// A pixel write (req_type 0) stores into the raw depth memory; its response is
// registered and shown in the cycle after acceptance. A read (req_type 2) returns
// a filtered pixel via the filtered memory's read register and then the output
// register. Out-of-frame addresses set address_error. A process command
// (req_type 1) runs in place: a presence scan (until a nonzero pixel is seen), a
// fill pass (skipped if none is seen; each hole takes the first nonzero pixel
// found on growing rings around it), then a median pass. These passes share
// the depth memory's single read port. Its response follows the median pass.
// The frame size registers are written through cfg_we/cfg_index/cfg_data and
// are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT when used.
// Reset clears the control state and sets the frame size to 640 x 480; the
// memories are not cleared and need no clearing pass.
// A response waits in an output register; while the receiver stalls, the
// block finishes its current work and holds off new requests until the
// output register is free again.
module depth_hole_fill_median_core #(
  parameter int MAX_WIDTH  = dhf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dhf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [dhf_pkg::CFG_D_W-1:0] cfg_data,
  dhf_req_if.sink                          req,
  dhf_rsp_if.source                        rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  // Signed coordinate width: room for ring corners on both sides of the frame.
  localparam int SW    = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 3;
  localparam int PW    = dhf_pkg::PIX_W;

  localparam logic signed [SW-1:0] ZERO  = '0;
  localparam logic signed [SW-1:0] ONE   = SW'(1);
  localparam logic signed [SW-1:0] MAXW  = SW'(MAX_WIDTH);
  localparam logic signed [SW-1:0] MAXH  = SW'(MAX_HEIGHT);

  // Configuration registers.
  logic [dhf_pkg::FW_W-1:0] frame_width;
  logic [dhf_pkg::FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dhf_pkg::FRAME_WIDTH_RST;
      frame_height <= dhf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == dhf_pkg::CFG_FRAME_WIDTH) begin
        frame_width <= cfg_data[dhf_pkg::FW_W-1:0];
      end else begin
        frame_height <= cfg_data[dhf_pkg::FH_W-1:0];
      end
    end
  end

  // Active frame size, clamped.
  logic signed [SW-1:0] fw_s, fh_s, aw, ah, aw_m1, ah_m1;
  always_comb begin
    fw_s = SW'(frame_width);
    fh_s = SW'(frame_height);
    aw   = (fw_s == ZERO) ? ONE : ((fw_s > MAXW) ? MAXW : fw_s);
    ah   = (fh_s == ZERO) ? ONE : ((fh_s > MAXH) ? MAXH : fh_s);
    aw_m1 = aw - ONE;
    ah_m1 = ah - ONE;
  end

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    addr_of = AW'(AW'(r) * AW'(MAX_WIDTH)) + AW'(c);
  endfunction

  // Memories.
  logic          dram_we, dram_re, fram_we, fram_re;
  logic [AW-1:0] dram_waddr, dram_raddr, fram_waddr, fram_raddr;
  logic [PW-1:0] dram_wdata, dram_rdata, fram_wdata, fram_rdata;

  dhf_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_depth_ram (
    .clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
    .re(dram_re), .raddr(dram_raddr), .rdata(dram_rdata)
  );

  dhf_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_filt_ram (
    .clk(clk), .we(fram_we), .waddr(fram_waddr), .wdata(fram_wdata),
    .re(fram_re), .raddr(fram_raddr), .rdata(fram_rdata)
  );

  // Sequencer state.
  dhf_pkg::state_t       state, state_next;
  logic signed [SW-1:0]  pr, pr_next, pc, pc_next;
  logic signed [SW-1:0]  rad, rad_next, idx, idx_next, hi, hi_next;
  logic [1:0]            seg, seg_next;
  logic [1:0]            dr, dr_next, dc, dc_next;
  logic [3:0]            n, n_next;
  logic [PW-1:0]         win [9];
  logic [PW-1:0]         win_next [9];
  logic                  out_valid, out_valid_next, out_err, out_err_next;
  logic [PW-1:0]         out_val, out_val_next;

  // Request decode.
  logic                  req_fire, req_bad, out_free;
  logic signed [SW-1:0]  req_row_s, req_col_s;
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == dhf_pkg::ST_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign req_row_s = SW'(req.row);
  assign req_col_s = SW'(req.col);
  assign req_bad   = (req_row_s >= ah) || (req_col_s >= aw);

  // Ring geometry.
  logic signed [SW-1:0] x1, x2, y1, y2, seg_lo, seg_hi;
  logic                 seg_en, ring_out;
  always_comb begin
    x1 = pc - rad;
    x2 = pc + rad;
    y1 = pr - rad;
    y2 = pr + rad;
    ring_out = (x1 < ZERO) && (x2 > aw_m1) && (y1 < ZERO) && (y2 > ah_m1);
    case (seg)
      2'd0: begin
        seg_en = (y1 >= ZERO);
        seg_lo = (x1 < ZERO) ? ZERO : x1;
        seg_hi = (x2 > aw_m1) ? aw_m1 : x2;
      end
      2'd1: begin
        seg_en = (y2 <= ah_m1);
        seg_lo = (x1 < ZERO) ? ZERO : x1;
        seg_hi = (x2 > aw_m1) ? aw_m1 : x2;
      end
      2'd2: begin
        seg_en = (x1 >= ZERO);
        seg_lo = (y1 < ZERO) ? ZERO : y1;
        seg_hi = (y2 > ah_m1) ? ah_m1 : y2;
      end
      default: begin
        seg_en = (x2 <= aw_m1);
        seg_lo = (y1 < ZERO) ? ZERO : y1;
        seg_hi = (y2 > ah_m1) ? ah_m1 : y2;
      end
    endcase
  end

  // Median window neighbor, clamped to the frame.
  logic signed [SW-1:0] nr, nc;
  always_comb begin
    nr = pr + SW'(dr) - ONE;
    nc = pc + SW'(dc) - ONE;
    if (nr < ZERO) nr = ZERO;
    else if (nr > ah_m1) nr = ah_m1;
    if (nc < ZERO) nc = ZERO;
    else if (nc > aw_m1) nc = aw_m1;
  end

  // Sorted insertion of the newest window value.
  logic [8:0] keep;
  always_comb begin
    for (int j = 0; j < 9; j++) begin
      keep[j] = (4'(j) < n) && !(win[j] > dram_rdata);
    end
  end

  // Raster stepping.
  logic last_px;
  logic signed [SW-1:0] pr_adv, pc_adv;
  assign last_px = (pc == aw_m1) && (pr == ah_m1);
  assign pc_adv  = (pc == aw_m1) ? ZERO : pc + ONE;
  assign pr_adv  = (pc == aw_m1) ? pr + ONE : pr;

  logic signed [SW-1:0] arow, acol;
  logic do_next_fill, do_seg_step, do_med_start;

  always_comb begin
    state_next     = state;
    pr_next        = pr;
    pc_next        = pc;
    rad_next       = rad;
    idx_next       = idx;
    hi_next        = hi;
    seg_next       = seg;
    dr_next        = dr;
    dc_next        = dc;
    n_next         = n;
    for (int j = 0; j < 9; j++) begin
      win_next[j] = win[j];
    end
    out_valid_next = out_valid;
    out_val_next   = out_val;
    out_err_next   = out_err;
    dram_we        = 1'b0;
    dram_re        = 1'b0;
    fram_we        = 1'b0;
    fram_re        = 1'b0;
    dram_wdata     = req.pixel_value;
    fram_wdata     = win[4];
    arow           = pr;
    acol           = pc;
    do_next_fill   = 1'b0;
    do_seg_step    = 1'b0;
    do_med_start   = 1'b0;
    dram_waddr     = addr_of(RW'(pr), CW'(pc));
    fram_waddr     = addr_of(RW'(pr), CW'(pc));
    fram_raddr     = addr_of(RW'(req.row), CW'(req.col));

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      dhf_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (dhf_pkg::req_t'(req.req_type))
            dhf_pkg::REQ_WRITE: begin
              dram_waddr     = addr_of(RW'(req.row), CW'(req.col));
              dram_we        = !req_bad;
              out_valid_next = 1'b1;
              out_val_next   = '0;
              out_err_next   = req_bad;
            end
            dhf_pkg::REQ_READ: begin
              if (req_bad) begin
                out_valid_next = 1'b1;
                out_val_next   = '0;
                out_err_next   = 1'b1;
              end else begin
                fram_re    = 1'b1;
                state_next = dhf_pkg::ST_RD_WAIT;
              end
            end
            dhf_pkg::REQ_PROCESS: begin
              pr_next    = ZERO;
              pc_next    = ZERO;
              state_next = dhf_pkg::ST_ANY_RD;
            end
            default: begin
              out_valid_next = 1'b1;
              out_val_next   = '0;
              out_err_next   = 1'b0;
            end
          endcase
        end
      end
      dhf_pkg::ST_RD_WAIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_val_next   = fram_rdata;
          out_err_next   = 1'b0;
          state_next     = dhf_pkg::ST_IDLE;
        end
      end
      dhf_pkg::ST_ANY_RD: begin
        dram_re    = 1'b1;
        state_next = dhf_pkg::ST_ANY_CHK;
      end
      dhf_pkg::ST_ANY_CHK: begin
        if (dram_rdata != '0) begin
          pr_next    = ZERO;
          pc_next    = ZERO;
          state_next = dhf_pkg::ST_FILL_RD;
        end else if (last_px) begin
          do_med_start = 1'b1;
        end else begin
          pr_next    = pr_adv;
          pc_next    = pc_adv;
          state_next = dhf_pkg::ST_ANY_RD;
        end
      end
      dhf_pkg::ST_FILL_RD: begin
        dram_re    = 1'b1;
        state_next = dhf_pkg::ST_FILL_CHK;
      end
      dhf_pkg::ST_FILL_CHK: begin
        if (dram_rdata == '0) begin
          rad_next   = ONE;
          state_next = dhf_pkg::ST_RING;
        end else begin
          do_next_fill = 1'b1;
        end
      end
      dhf_pkg::ST_RING: begin
        if (ring_out) begin
          do_next_fill = 1'b1;
        end else begin
          seg_next   = 2'd0;
          state_next = dhf_pkg::ST_SEG;
        end
      end
      dhf_pkg::ST_SEG: begin
        if (seg_en) begin
          idx_next   = seg_lo;
          hi_next    = seg_hi;
          state_next = dhf_pkg::ST_SRCH_RD;
        end else begin
          do_seg_step = 1'b1;
        end
      end
      dhf_pkg::ST_SRCH_RD: begin
        dram_re = 1'b1;
        case (seg)
          2'd0: begin
            arow = y1;
            acol = idx;
          end
          2'd1: begin
            arow = y2;
            acol = idx;
          end
          2'd2: begin
            arow = idx;
            acol = x1;
          end
          default: begin
            arow = idx;
            acol = x2;
          end
        endcase
        state_next = dhf_pkg::ST_SRCH_CHK;
      end
      dhf_pkg::ST_SRCH_CHK: begin
        if (dram_rdata != '0) begin
          dram_we      = 1'b1;
          dram_wdata   = dram_rdata;
          do_next_fill = 1'b1;
        end else if (idx == hi) begin
          do_seg_step = 1'b1;
        end else begin
          idx_next   = idx + ONE;
          state_next = dhf_pkg::ST_SRCH_RD;
        end
      end
      dhf_pkg::ST_MED_RD: begin
        dram_re    = 1'b1;
        arow       = nr;
        acol       = nc;
        state_next = dhf_pkg::ST_MED_CAP;
      end
      dhf_pkg::ST_MED_CAP: begin
        for (int j = 0; j < 9; j++) begin
          if (keep[j]) begin
            win_next[j] = win[j];
          end else if (j == 0) begin
            win_next[j] = dram_rdata;
          end else if (keep[j-1]) begin
            win_next[j] = dram_rdata;
          end else begin
            win_next[j] = win[j-1];
          end
        end
        n_next = n + 4'd1;
        if (dc == 2'd2) begin
          dc_next = 2'd0;
          if (dr == 2'd2) begin
            state_next = dhf_pkg::ST_MED_WR;
          end else begin
            dr_next    = dr + 2'd1;
            state_next = dhf_pkg::ST_MED_RD;
          end
        end else begin
          dc_next    = dc + 2'd1;
          state_next = dhf_pkg::ST_MED_RD;
        end
      end
      dhf_pkg::ST_MED_WR: begin
        fram_we = 1'b1;
        n_next  = 4'd0;
        dr_next = 2'd0;
        dc_next = 2'd0;
        if (last_px) begin
          state_next = dhf_pkg::ST_DONE;
        end else begin
          pr_next    = pr_adv;
          pc_next    = pc_adv;
          state_next = dhf_pkg::ST_MED_RD;
        end
      end
      dhf_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_val_next   = '0;
          out_err_next   = 1'b0;
          state_next     = dhf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dhf_pkg::ST_IDLE;
      end
    endcase

    // The ring of the current hole moves to its next side or grows.
    if (do_seg_step) begin
      if (seg == 2'd3) begin
        rad_next   = rad + ONE;
        state_next = dhf_pkg::ST_RING;
      end else begin
        seg_next   = seg + 2'd1;
        state_next = dhf_pkg::ST_SEG;
      end
    end

    if (do_next_fill) begin
      if (last_px) begin
        do_med_start = 1'b1;
      end else begin
        pr_next    = pr_adv;
        pc_next    = pc_adv;
        state_next = dhf_pkg::ST_FILL_RD;
      end
    end

    if (do_med_start) begin
      pr_next    = ZERO;
      pc_next    = ZERO;
      dr_next    = 2'd0;
      dc_next    = 2'd0;
      n_next     = 4'd0;
      state_next = dhf_pkg::ST_MED_RD;
    end

    dram_raddr = addr_of(RW'(arow), CW'(acol));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dhf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pr      <= pr_next;
    pc      <= pc_next;
    rad     <= rad_next;
    idx     <= idx_next;
    hi      <= hi_next;
    seg     <= seg_next;
    dr      <= dr_next;
    dc      <= dc_next;
    n       <= n_next;
    out_val <= out_val_next;
    out_err <= out_err_next;
    for (int j = 0; j < 9; j++) begin
      win[j] <= win_next[j];
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_value    = out_val;
  assign rsp.address_error = out_err;

endmodule
`default_nettype wire
